[rtl/trs_pkg.sv]
// Shared widths, register indexes and lane types of the tick ratio scaler.
package trs_pkg;

    localparam int unsigned TICK_W    = 64;
    localparam int unsigned RATIO_W   = 32;
    localparam int unsigned PROD_W    = TICK_W + RATIO_W;
    localparam int unsigned CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR    = 2'd1;

    // One slot of the divider chain: partial remainder plus a word that
    // holds the unused dividend bits at the top and quotient bits below.
    typedef struct packed {
        logic               valid;
        logic [RATIO_W-1:0] rem;
        logic [PROD_W-1:0]  dq;
    } t_div_lane;

    // One finished result item.
    typedef struct packed {
        logic [TICK_W-1:0] scaled_time;
        logic              overflow;
    } t_result;

endpackage

[rtl/tick_ratio_scaler.sv]
// Top level of the tick ratio scaler: tick count times multiplier over divisor.
//
// Usage:
//   The slave stream takes one 64-bit tick count per item on i_s_tdata. The
//   master stream returns floor(tick * multiplier / divisor) truncated to
//   64 bits on o_m_tdata, with an overflow flag on o_m_tuser that is set
//   when the true quotient needs more than 64 bits. A zero divisor gives an
//   all-ones result with the overflow flag set.
//   The configuration channel writes index 0 (multiplier) or 1 (divisor);
//   other indexes are ignored. Write only while no items are in flight.
// Timing:
//   An item passes two multiplier stages and a chain of 96 division cells,
//   one quotient bit per cell, then enters a two-entry output queue. One
//   item is accepted per cycle while the output queue has room. When the
//   receiver stalls, the chain keeps moving until the output queue holds
//   two results; the whole chain then holds and o_s_tready drops until the
//   receiver takes a result.
// Reset:
//   Both ratio registers return to 1 and all items in flight are dropped.
module tick_ratio_scaler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Slave stream. tdata: [63:0] tick_count.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [trs_pkg::TICK_W-1:0]        i_s_tdata,
    // Master stream. tdata: [63:0] scaled_time. tuser: [0] overflow.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [trs_pkg::TICK_W-1:0]        o_m_tdata,
    output logic                              o_m_tuser,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [trs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [trs_pkg::RATIO_W-1:0]       i_cfg_data
);

    localparam int unsigned NCELLS = trs_pkg::PROD_W;

    logic [trs_pkg::RATIO_W-1:0] r_mult;
    logic [trs_pkg::RATIO_W-1:0] r_div;
    logic                        w_en;
    logic                        w_push;
    trs_pkg::t_div_lane          w_lane [0:NCELLS];
    trs_pkg::t_result            w_result;
    trs_pkg::t_result            w_out;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult <= 32'd1;
            r_div  <= 32'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                trs_pkg::CFG_MULTIPLIER: r_mult <= i_cfg_data;
                trs_pkg::CFG_DIVISOR:    r_div  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The chain advances whenever the output queue has room.
    assign o_s_tready = w_en;

    trs_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_tick  (i_s_tdata),
        .i_mult  (r_mult),
        .o_lane  (w_lane[0])
    );

    // Chain of division cells, most significant quotient bit first.
    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        trs_div_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_en),
            .i_divisor (r_div),
            .i_lane    (w_lane[g]),
            .o_lane    (w_lane[g+1])
        );
    end

    // Form the result; a zero divisor forces the saturated answer.
    always_comb begin
        if (r_div == '0) begin
            w_result.scaled_time = '1;
            w_result.overflow    = 1'b1;
        end else begin
            w_result.scaled_time = w_lane[NCELLS].dq[trs_pkg::TICK_W-1:0];
            w_result.overflow    = |w_lane[NCELLS].dq[trs_pkg::PROD_W-1:trs_pkg::TICK_W];
        end
    end

    assign w_push = w_en && w_lane[NCELLS].valid;

    trs_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .i_ready (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_data  (w_out),
        .o_space (w_en)
    );

    assign o_m_tdata = w_out.scaled_time;
    assign o_m_tuser = w_out.overflow;

    // The input side only stalls while results are waiting at the output.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with no result waiting");

    // A zero divisor always yields the saturated result.
    a_zero_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_div == '0) |-> (o_m_tuser && o_m_tdata == '1))
        else $error("zero divisor result not saturated");

    // A zero multiplier with a valid divisor always yields zero.
    a_zero_multiplier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_mult == '0 && r_div != '0) |-> (!o_m_tuser && o_m_tdata == '0))
        else $error("zero multiplier gave a nonzero result");

endmodule

[rtl/trs_mul.sv]
// Two-stage 64x32 multiplier that feeds the 96-bit product into the divider chain.
module trs_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [trs_pkg::TICK_W-1:0]    i_tick,
    input  logic [trs_pkg::RATIO_W-1:0]   i_mult,
    output trs_pkg::t_div_lane            o_lane
);

    logic [63:0]                   n_plo;
    logic [63:0]                   n_phi;
    logic [63:0]                   r_plo;
    logic [63:0]                   r_phi;
    logic                          r_v1;
    logic [trs_pkg::PROD_W-1:0]    n_prod;
    logic [trs_pkg::PROD_W-1:0]    r_prod;
    logic                          r_v2;

    // Two 32x32 partial products, one per half of the tick count.
    assign n_plo = {32'b0, i_tick[31:0]}  * {32'b0, i_mult};
    assign n_phi = {32'b0, i_tick[63:32]} * {32'b0, i_mult};

    // Combine the partial products into the full 96-bit product.
    assign n_prod = {r_phi, 32'b0} + {32'b0, r_plo};

    // Valid flags of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Payload of both stages.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_plo  <= n_plo;
            r_phi  <= n_phi;
            r_prod <= n_prod;
        end
    end

    assign o_lane.valid = r_v2;
    assign o_lane.rem   = '0;
    assign o_lane.dq    = r_prod;

endmodule

[rtl/trs_div_cell.sv]
// One restoring division cell: settles one quotient bit per item passing through.
module trs_div_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [trs_pkg::RATIO_W-1:0]   i_divisor,
    input  trs_pkg::t_div_lane            i_lane,
    output trs_pkg::t_div_lane            o_lane
);

    logic [trs_pkg::RATIO_W:0]   w_trial;
    logic [trs_pkg::RATIO_W:0]   w_diff;
    logic                        w_ge;
    logic [trs_pkg::RATIO_W-1:0] n_rem;
    logic [trs_pkg::PROD_W-1:0]  n_dq;
    logic                        r_valid;
    logic [trs_pkg::RATIO_W-1:0] r_rem;
    logic [trs_pkg::PROD_W-1:0]  r_dq;

    // Bring down the next dividend bit and try to subtract the divisor.
    assign w_trial = {i_lane.rem, i_lane.dq[trs_pkg::PROD_W-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign w_ge    = (w_trial >= {1'b0, i_divisor});
    assign n_rem   = w_ge ? w_diff[trs_pkg::RATIO_W-1:0] : w_trial[trs_pkg::RATIO_W-1:0];
    assign n_dq    = {i_lane.dq[trs_pkg::PROD_W-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_lane.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_dq  <= n_dq;
        end
    end

    assign o_lane.valid = r_valid;
    assign o_lane.rem   = r_rem;
    assign o_lane.dq    = r_dq;

endmodule

[rtl/trs_out_queue.sv]
// Two-entry output queue that decouples the divider chain from the receiver.
module trs_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  trs_pkg::t_result   i_data,
    input  logic               i_ready,
    output logic               o_valid,
    output trs_pkg::t_result   o_data,
    output logic               o_space
);

    trs_pkg::t_result r_mem [0:1];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_count;
    logic             w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_space = (r_count != 2'd2);
    assign o_data  = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && w_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule
